// ===== src/cmyk_rgb_pixel_converter_core_assert.svh =====
// Assertion macros used by the CMYK/RGB converter top level.
`ifndef CMYK_RGB_PIXEL_CONVERTER_CORE_ASSERT_SVH
`define CMYK_RGB_PIXEL_CONVERTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every clock edge outside reset.
`define CRGB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("crgb: assertion failed");

// Checks that a condition on one edge implies another on the next edge.
`define CRGB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crgb: assertion failed");

`else

`define CRGB_ASSERT(lbl, clk, rst, prop)
`define CRGB_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== src/crgb_pkg.sv =====
// Shared types, constants and helpers for the CMYK/RGB pixel converter.
`timescale 1ns / 1ps

package crgb_pkg;

  localparam int unsigned NUM_STAGES = 5;

  localparam logic OP_CMYK2RGB = 1'b0;
  localparam logic OP_RGB2CMYK = 1'b1;

  localparam logic [6:0]  PCT_FULL  = 7'd100;
  localparam logic [7:0]  BYTE_FULL = 8'd255;
  localparam logic [13:0] PCT_SQ    = 14'd10000;
  localparam logic [8:0]  BLACK_DIV = 9'd510;

  // Reciprocal of 10000 scaled by 2^24, and the shift that goes with it.
  localparam int unsigned DIV_SHIFT = 24;
  localparam logic [10:0] RECIP_10K = 11'(2**24 / 10000);

  // Reciprocals of 2*m are scaled by 2^16.
  localparam int unsigned RECIP_SHIFT = 16;
  // Dividing by 510 is estimated by a shift of 9, then corrected.
  localparam int unsigned BLACK_SHIFT = 9;

  // Input pixel, lowest field in the lowest bits; op sits on top.
  typedef struct packed {
    logic       op;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [6:0] key_black;
    logic [6:0] yellow;
    logic [6:0] magenta;
    logic [6:0] cyan;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] alpha_out;
    logic [6:0] black_out;
    logic [6:0] yellow_out;
    logic [6:0] magenta_out;
    logic [6:0] cyan_out;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } pix_out_t;

  // Complement of a percentage, with inputs above 100 saturated first.
  function automatic logic [6:0] sat_comp(input logic [6:0] v);
    return (v > PCT_FULL) ? 7'd0 : PCT_FULL - v;
  endfunction

endpackage

// ===== src/crgb_datapath.sv =====
// Five-stage arithmetic pipeline for both conversion directions.
`timescale 1ns / 1ps

module crgb_datapath (
  input  logic                               clk,
  input  logic [crgb_pkg::NUM_STAGES-1:0]    en,
  input  crgb_pkg::pix_in_t                  pix_in,
  output crgb_pkg::pix_out_t                 pix_out
);
  import crgb_pkg::*;

  // Reciprocal table: floor(2^16 / (2*m)); entry zero is unused.
  logic [15:0] recip_tab [256];
  assign recip_tab[0] = 16'd0;
  for (genvar i = 1; i < 256; i++) begin : g_recip
    localparam int unsigned RV = 32768 / i;
    assign recip_tab[i] = 16'(RV);
  end

  // Stage 1: saturate and complement inks, find the largest channel.
  logic       s1_op;
  logic [7:0] s1_alpha;
  logic [6:0] s1_comp [3];
  logic [6:0] s1_kcomp;
  logic [7:0] s1_m;
  logic [7:0] s1_d [3];
  logic [7:0] m_in;
  logic [7:0] ch_in [3];

  always_comb begin
    ch_in[0] = pix_in.red;
    ch_in[1] = pix_in.green;
    ch_in[2] = pix_in.blue;
    m_in = ch_in[0];
    if (ch_in[1] > m_in) m_in = ch_in[1];
    if (ch_in[2] > m_in) m_in = ch_in[2];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_op      <= pix_in.op;
      s1_alpha   <= pix_in.alpha;
      s1_comp[0] <= sat_comp(pix_in.cyan);
      s1_comp[1] <= sat_comp(pix_in.magenta);
      s1_comp[2] <= sat_comp(pix_in.yellow);
      s1_kcomp   <= sat_comp(pix_in.key_black);
      s1_m       <= m_in;
      for (int i = 0; i < 3; i++) begin
        s1_d[i] <= m_in - ch_in[i];
      end
    end
  end

  // Stage 2: ink products, rounding numerators and the reciprocal lookup.
  logic        s2_op;
  logic [7:0]  s2_alpha;
  logic [13:0] s2_p [3];
  logic [15:0] s2_n [3];
  logic [15:0] s2_nb;
  logic [15:0] s2_recip;
  logic [7:0]  s2_m;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_op    <= s1_op;
      s2_alpha <= s1_alpha;
      s2_m     <= s1_m;
      s2_recip <= recip_tab[s1_m];
      s2_nb    <= 16'(BYTE_FULL - s1_m) * 16'd200 + 16'(BYTE_FULL);
      for (int i = 0; i < 3; i++) begin
        s2_p[i] <= 14'(s1_comp[i]) * 14'(s1_kcomp);
        s2_n[i] <= 16'(s1_d[i]) * 16'd200 + 16'(s1_m);
      end
    end
  end

  // Stage 3: scale products by 255; multiply numerators by the reciprocal.
  logic        s3_op;
  logic [7:0]  s3_alpha;
  logic [21:0] s3_x [3];
  logic [31:0] s3_prod [3];
  logic [15:0] s3_n [3];
  logic [15:0] s3_nb;
  logic [7:0]  s3_m;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_op    <= s2_op;
      s3_alpha <= s2_alpha;
      s3_m     <= s2_m;
      s3_nb    <= s2_nb;
      for (int i = 0; i < 3; i++) begin
        s3_x[i]    <= 22'(s2_p[i]) * 22'(BYTE_FULL);
        s3_prod[i] <= 32'(s2_n[i]) * 32'(s2_recip);
        s3_n[i]    <= s2_n[i];
      end
    end
  end

  // Stage 4: reciprocal multiply for the channel quotient; take the ink
  // and black estimates, which are exact or one short.
  logic        s4_op;
  logic [7:0]  s4_alpha;
  logic [32:0] s4_y [3];
  logic [21:0] s4_x [3];
  logic [6:0]  s4_qe [3];
  logic [15:0] s4_n [3];
  logic [6:0]  s4_qb;
  logic [15:0] s4_nb;
  logic [7:0]  s4_m;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_op    <= s3_op;
      s4_alpha <= s3_alpha;
      s4_m     <= s3_m;
      s4_nb    <= s3_nb;
      s4_qb    <= s3_nb[BLACK_SHIFT +: 7];
      for (int i = 0; i < 3; i++) begin
        s4_y[i]  <= 33'(s3_x[i]) * 33'(RECIP_10K);
        s4_x[i]  <= s3_x[i];
        s4_qe[i] <= s3_prod[i][RECIP_SHIFT +: 7];
        s4_n[i]  <= s3_n[i];
      end
    end
  end

  // Stage 5: one correction step per quotient, then select the direction.
  logic [7:0]  chan_est [3];
  logic [7:0]  chan_fix [3];
  logic [6:0]  ink_fix [3];
  logic [6:0]  black_fix;
  logic [22:0] chan_chk [3];
  logic [16:0] ink_chk [3];
  logic [15:0] black_chk;
  logic [8:0]  two_m;

  always_comb begin
    two_m     = {s4_m, 1'b0};
    black_chk = 16'(s4_qb + 7'd1) * 16'(BLACK_DIV);
    black_fix = (black_chk <= s4_nb) ? s4_qb + 7'd1 : s4_qb;
    for (int i = 0; i < 3; i++) begin
      chan_est[i] = s4_y[i][DIV_SHIFT +: 8];
      chan_chk[i] = 23'(9'(chan_est[i]) + 9'd1) * 23'(PCT_SQ);
      chan_fix[i] = (chan_chk[i] <= 23'(s4_x[i])) ? chan_est[i] + 8'd1 : chan_est[i];
      ink_chk[i]  = 17'(8'(s4_qe[i]) + 8'd1) * 17'(two_m);
      if (s4_m == 8'd0) begin
        ink_fix[i] = 7'd0;
      end else begin
        ink_fix[i] = (ink_chk[i] <= 17'(s4_n[i])) ? s4_qe[i] + 7'd1 : s4_qe[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      pix_out.alpha_out <= s4_alpha;
      if (s4_op == OP_CMYK2RGB) begin
        pix_out.red_out     <= chan_fix[0];
        pix_out.green_out   <= chan_fix[1];
        pix_out.blue_out    <= chan_fix[2];
        pix_out.cyan_out    <= 7'd0;
        pix_out.magenta_out <= 7'd0;
        pix_out.yellow_out  <= 7'd0;
        pix_out.black_out   <= 7'd0;
      end else begin
        pix_out.red_out     <= 8'd0;
        pix_out.green_out   <= 8'd0;
        pix_out.blue_out    <= 8'd0;
        pix_out.cyan_out    <= ink_fix[0];
        pix_out.magenta_out <= ink_fix[1];
        pix_out.yellow_out  <= ink_fix[2];
        pix_out.black_out   <= black_fix;
      end
    end
  end

endmodule

// ===== src/cmyk_rgb_pixel_converter_core.sv =====
// Top level of the streaming CMYK/RGB pixel converter.
`timescale 1ns / 1ps
`include "cmyk_rgb_pixel_converter_core_assert.svh"

// Usage:
// Pixels enter on the slave stream (s_axis_*). The tuser bit picks the
// direction for each pixel: 0 turns cyan, magenta, yellow and black
// percentages into red, green and blue bytes, 1 turns red, green and blue
// bytes into the four percentages. Alpha is copied through in both cases.
// Results leave on the master stream (m_axis_*); the fields of the unused
// direction are zero. Every input transfer gives exactly one output transfer.
// Output valid is the last stage's valid bit, so each pixel passes through
// every stage register in order before it can leave. The block takes one
// pixel per clock while the receiver keeps up; the figure is set by the
// five-stage arithmetic pipeline, whose slowest step is a reciprocal multiply
// for the per-pixel divisions, followed by a single correction stage.
// Each stage holds its own valid bit. When the receiver stalls, the output
// stage holds its pixel and earlier stages keep filling empty slots, so
// input is refused only once every stage holds a pixel. Nothing is lost or
// repeated across a stall. A synchronous reset empties the pipeline; no
// table or memory needs to be cleared afterwards.

module cmyk_rgb_pixel_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cyan[6:0], magenta[13:7], yellow[20:14], key_black[27:21], red[35:28],
  // green[43:36], blue[51:44], alpha[59:52], zero pad[63:60]
  input  logic [63:0] s_axis_tdata,
  // op[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], cyan_out[30:24],
  // magenta_out[37:31], yellow_out[44:38], black_out[51:45],
  // alpha_out[59:52], zero pad[63:60]
  output logic [63:0] m_axis_tdata
);
  import crgb_pkg::*;

  pix_in_t                 pix_in;
  pix_out_t                pix_out;
  logic [NUM_STAGES-1:0]   vld;
  logic [NUM_STAGES-1:0]   en;

  // The payload below the pad bits lines up with the packed struct.
  assign pix_in = {s_axis_tuser, s_axis_tdata[59:0]};

  // A stage may load when it is empty or when the stage after it moves.
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  crgb_datapath u_datapath (
    .clk     (clk),
    .en      (en),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NUM_STAGES-1];
  assign m_axis_tdata  = {4'd0, pix_out};

  // The number of pixels in flight changes only by the transfers taken.
  `CRGB_ASSERT_NEXT(a_occupancy, clk, rst, 1'b1, $countones(vld) == $countones($past(vld)) + int'($past(s_axis_tvalid && s_axis_tready)) - int'($past(m_axis_tvalid && m_axis_tready)))

  // A ready receiver lets the whole pipeline advance.
  `CRGB_ASSERT(a_ready_chain, clk, rst, m_axis_tready |-> s_axis_tready)

  // Only one direction's fields are populated in a result.
  `CRGB_ASSERT(a_one_direction, clk, rst, m_axis_tvalid |-> ((pix_out.red_out == 8'd0 && pix_out.green_out == 8'd0 && pix_out.blue_out == 8'd0) || (pix_out.cyan_out == 7'd0 && pix_out.magenta_out == 7'd0 && pix_out.yellow_out == 7'd0 && pix_out.black_out == 7'd0)))

  // Percentages produced never exceed full scale.
  `CRGB_ASSERT(a_pct_range, clk, rst, m_axis_tvalid |-> (pix_out.cyan_out <= PCT_FULL && pix_out.magenta_out <= PCT_FULL && pix_out.yellow_out <= PCT_FULL && pix_out.black_out <= PCT_FULL))

endmodule

// ===== tb/tb_cmyk_rgb_pixel_converter_core.sv =====
// Self-checking testbench for the streaming CMYK/RGB pixel converter.
`timescale 1ns / 1ps

module tb_cmyk_rgb_pixel_converter_core;

  import crgb_pkg::*;

  // Percent and byte full scale, as used by the conversion formulas.
  localparam int unsigned PCT  = 100;
  localparam int unsigned FULL = 255;

  // Cycles after the last expected result in which a stray transfer would still show up.
  localparam int unsigned SETTLE_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // cyan[6:0], magenta[13:7], yellow[20:14], key_black[27:21], red[35:28],
  // green[43:36], blue[51:44], alpha[59:52], zero pad[63:60]
  logic [63:0] s_axis_tdata = '0;
  // op[0]
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // red_out[7:0], green_out[15:8], blue_out[23:16], cyan_out[30:24],
  // magenta_out[37:31], yellow_out[44:38], black_out[51:45],
  // alpha_out[59:52], zero pad[63:60]
  logic [63:0] m_axis_tdata;

  // Converted pixels still owed by the block, oldest first.
  pix_out_t    pending_pixels[$];

  // When set, neither side inserts idle cycles between transfers.
  bit          hold_tx = 1'b0;
  bit          hold_rx = 1'b0;

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned pixels_cmyk   = 0;
  int unsigned pixels_rgb    = 0;
  int unsigned pixels_sat    = 0;
  int unsigned pixels_dark   = 0;
  int unsigned rx_wait       = 0;

  cmyk_rgb_pixel_converter_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Expected-value computation
  // ---------------------------------------------------------------------------

  // Share of white left by an ink; an ink above full scale counts as full.
  function automatic int unsigned ink_complement(input logic [6:0] ink);
    return (32'(ink) > PCT) ? 0 : PCT - 32'(ink);
  endfunction

  // Ink needed to pull a channel down from the brightest one, rounded half up.
  function automatic logic [6:0] ink_from_channel(input int unsigned chan,
                                                  input int unsigned peak);
    return 7'((2 * PCT * (peak - chan) + peak) / (2 * peak));
  endfunction

  function automatic pix_out_t convert_pixel(input pix_in_t px);
    pix_out_t    res;
    int unsigned white;
    int unsigned peak;
    res = '0;
    res.alpha_out = px.alpha;
    if (px.op == OP_CMYK2RGB) begin
      white = ink_complement(px.key_black);
      res.red_out   = 8'((FULL * ink_complement(px.cyan) * white) / (PCT * PCT));
      res.green_out = 8'((FULL * ink_complement(px.magenta) * white) / (PCT * PCT));
      res.blue_out  = 8'((FULL * ink_complement(px.yellow) * white) / (PCT * PCT));
    end else begin
      peak = 32'(px.red);
      if (32'(px.green) > peak) peak = 32'(px.green);
      if (32'(px.blue) > peak) peak = 32'(px.blue);
      if (peak == 0) begin
        // A black pixel has no hue, so it is pure key with no colored ink.
        res.black_out = 7'(PCT);
      end else begin
        res.cyan_out    = ink_from_channel(32'(px.red), peak);
        res.magenta_out = ink_from_channel(32'(px.green), peak);
        res.yellow_out  = ink_from_channel(32'(px.blue), peak);
        res.black_out   = 7'((2 * PCT * (FULL - peak) + FULL) / (2 * FULL));
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking on the master side
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_pixel(input logic [63:0] word);
    pix_out_t want;
    pix_out_t got;
    got = pix_out_t'(word[59:0]);
    results_seen++;
    if (pending_pixels.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, actual %h", $time, word);
      mismatches++;
    end else begin
      want = pending_pixels.pop_front();
      compare_field("red_out",     32'(want.red_out),     32'(got.red_out));
      compare_field("green_out",   32'(want.green_out),   32'(got.green_out));
      compare_field("blue_out",    32'(want.blue_out),    32'(got.blue_out));
      compare_field("cyan_out",    32'(want.cyan_out),    32'(got.cyan_out));
      compare_field("magenta_out", 32'(want.magenta_out), 32'(got.magenta_out));
      compare_field("yellow_out",  32'(want.yellow_out),  32'(got.yellow_out));
      compare_field("black_out",   32'(want.black_out),   32'(got.black_out));
      compare_field("alpha_out",   32'(want.alpha_out),   32'(got.alpha_out));
    end
  endtask

  // The receiver checks every transfer and then, unless hold_rx is set, stalls for a
  // random number of cycles before it takes the next one. Values seen here are those
  // sampled by the block at this same edge, since the block's own updates land later.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else if (m_axis_tready) begin
      if (m_axis_tvalid) begin
        check_pixel(m_axis_tdata);
        rx_wait = hold_rx ? 0 : $urandom_range(0, 8);
        if (rx_wait != 0) m_axis_tready <= 1'b0;
      end
    end else begin
      if (rx_wait <= 1) m_axis_tready <= 1'b1;
      if (rx_wait != 0) rx_wait = rx_wait - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus on the slave side
  // ---------------------------------------------------------------------------

  function automatic pix_in_t make_pixel(input logic op, input logic [6:0] c,
                                         input logic [6:0] mg, input logic [6:0] y,
                                         input logic [6:0] k, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b,
                                         input logic [7:0] a);
    pix_in_t px;
    px.op = op;
    px.cyan = c;
    px.magenta = mg;
    px.yellow = y;
    px.key_black = k;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.alpha = a;
    return px;
  endfunction

  // Mostly legal percentages, with full scale, zero and over-range values mixed in.
  function automatic logic [6:0] random_ink();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 7'(PCT) : 7'd0;
      1:       return 7'($urandom_range(PCT + 1, 127));
      default: return 7'($urandom_range(0, PCT));
    endcase
  endfunction

  // Uniform bytes, with extremes and very dark values that stress the rounding.
  function automatic logic [7:0] random_channel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    logic [7:0] grey;
    px = make_pixel($urandom_range(0, 1) ? OP_RGB2CMYK : OP_CMYK2RGB,
                    random_ink(), random_ink(), random_ink(), random_ink(),
                    random_channel(), random_channel(), random_channel(),
                    8'($urandom_range(0, 255)));
    // Occasionally make a neutral pixel; converted to CMYK, its three inks come out equal.
    if ($urandom_range(0, 15) == 0) begin
      grey = random_channel();
      px.red = grey;
      px.green = grey;
      px.blue = grey;
    end
    return px;
  endfunction

  // Presents one pixel after a random gap and returns at the edge of its
  // transfer. The valid stays high for a back-to-back pixel, so it is never
  // lowered and raised again within one time step.
  task automatic send_pixel(input pix_in_t px);
    int unsigned gap;
    gap = hold_tx ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, px[59:0]};
    s_axis_tuser  <= px.op;
    do @(posedge clk); while (!s_axis_tready);
    pending_pixels.insert(pending_pixels.size(), convert_pixel(px));
    if (px.op == OP_CMYK2RGB) begin
      pixels_cmyk++;
      if (32'(px.cyan) > PCT || 32'(px.magenta) > PCT || 32'(px.yellow) > PCT ||
          32'(px.key_black) > PCT)
        pixels_sat++;
    end else begin
      pixels_rgb++;
      if (px.red == 8'd0 && px.green == 8'd0 && px.blue == 8'd0) pixels_dark++;
    end
  endtask

  // Drops valid and waits until every converted pixel has come back.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corners of both directions: full scale, zero, over-range inks that must
  // saturate, the black pixel, primaries, and rounding that lands on a half.
  task automatic test_directed();
    // CMYK to RGB. The unused byte fields carry patterns that must be ignored.
    send_pixel(make_pixel(OP_CMYK2RGB, 7'd0, 7'd0, 7'd0, 7'd0,
                          8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_pixel(make_pixel(OP_CMYK2RGB, 7'd100, 7'd100, 7'd100, 7'd100,
                          8'd0, 8'd0, 8'd0, 8'hFF));
    send_pixel(make_pixel(OP_CMYK2RGB, 7'd0, 7'd50, 7'd100, 7'd0,
                          8'hAA, 8'h55, 8'h0F, 8'h5A));
    send_pixel(make_pixel(OP_CMYK2RGB, 7'd0, 7'd0, 7'd0, 7'd100,
                          8'd0, 8'd0, 8'd0, 8'hA5));
    send_pixel(make_pixel(OP_CMYK2RGB, 7'd127, 7'd101, 7'd100, 7'd0,
                          8'd0, 8'd0, 8'd0, 8'h01));
    send_pixel(make_pixel(OP_CMYK2RGB, 7'd1, 7'd99, 7'd33, 7'd127,
                          8'd0, 8'd0, 8'd0, 8'h80));
    send_pixel(make_pixel(OP_CMYK2RGB, 7'd10, 7'd20, 7'd30, 7'd40,
                          8'h12, 8'h34, 8'h56, 8'h7F));
    send_pixel(make_pixel(OP_CMYK2RGB, 7'd0, 7'd0, 7'd0, 7'd1,
                          8'd0, 8'd0, 8'd0, 8'hFE));
    send_pixel(make_pixel(OP_CMYK2RGB, 7'h55, 7'h2A, 7'h7F, 7'h2A, 8'hAA, 8'h55, 8'hFF,
                          8'h55));
    // RGB to CMYK. The unused ink fields carry patterns that must be ignored.
    send_pixel(make_pixel(OP_RGB2CMYK, 7'd127, 7'd127, 7'd127, 7'd127,
                          8'd0, 8'd0, 8'd0, 8'h33));
    send_pixel(make_pixel(OP_RGB2CMYK, 7'd0, 7'd0, 7'd0, 7'd0,
                          8'd255, 8'd255, 8'd255, 8'hCC));
    send_pixel(make_pixel(OP_RGB2CMYK, 7'h55, 7'h2A, 7'd0, 7'd0,
                          8'd255, 8'd0, 8'd0, 8'h00));
    send_pixel(make_pixel(OP_RGB2CMYK, 7'd0, 7'd0, 7'd0, 7'd0,
                          8'd0, 8'd255, 8'd0, 8'hFF));
    send_pixel(make_pixel(OP_RGB2CMYK, 7'd0, 7'd0, 7'd0, 7'd0,
                          8'd0, 8'd0, 8'd255, 8'h0F));
    send_pixel(make_pixel(OP_RGB2CMYK, 7'd0, 7'd0, 7'd0, 7'd0,
                          8'd1, 8'd0, 8'd0, 8'hF0));
    send_pixel(make_pixel(OP_RGB2CMYK, 7'd0, 7'd0, 7'd0, 7'd0,
                          8'd8, 8'd7, 8'd0, 8'h11));
    send_pixel(make_pixel(OP_RGB2CMYK, 7'd0, 7'd0, 7'd0, 7'd0,
                          8'd2, 8'd1, 8'd1, 8'h22));
    send_pixel(make_pixel(OP_RGB2CMYK, 7'd0, 7'd0, 7'd0, 7'd0,
                          8'h55, 8'hAA, 8'h33, 8'h44));
    send_pixel(make_pixel(OP_RGB2CMYK, 7'd0, 7'd0, 7'd0, 7'd0,
                          8'd128, 8'd64, 8'd32, 8'h99));
    send_pixel(make_pixel(OP_RGB2CMYK, 7'd0, 7'd0, 7'd0, 7'd0,
                          8'd100, 8'd100, 8'd100, 8'h77));
    send_pixel(make_pixel(OP_RGB2CMYK, 7'd0, 7'd0, 7'd0, 7'd0,
                          8'd1, 8'd1, 8'd254, 8'h66));
  endtask

  // Random pixels of both directions with random gaps and stalls on both sides.
  task automatic test_random_mix(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // Full rate: a transfer on every clock both in and out.
  task automatic test_full_rate(input int unsigned count);
    hold_tx = 1'b1;
    hold_rx = 1'b1;
    repeat (count) send_pixel(random_pixel());
    hold_tx = 1'b0;
    hold_rx = 1'b0;
  endtask

  // Bursts separated by a complete drain, so the pipeline restarts from empty.
  task automatic test_drain_between_bursts(input int unsigned bursts,
                                           input int unsigned burst_len);
    repeat (bursts) begin
      repeat (burst_len) send_pixel(random_pixel());
      drain_pipeline();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_mix(600);
    test_full_rate(150);
    test_drain_between_bursts(4, 20);

    drain_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d CMYK pixels (%0d with over-range inks) and %0d RGB pixels",
             pixels_cmyk, pixels_sat, pixels_rgb);
    $display("(%0d all black); %0d results compared, %0d mismatches.",
             pixels_dark, results_seen, mismatches);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("cmyk_rgb_pixel_converter_core verification clean");
    end else begin
      $display("cmyk_rgb_pixel_converter_core verification failed");
    end
    $finish;
  end

  // Guards against a hung handshake; the slowest correct run is far shorter.
  initial begin
    #500_000;
    $display("cmyk_rgb_pixel_converter_core verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/crgb_pkg.sv
src/crgb_datapath.sv
src/cmyk_rgb_pixel_converter_core.sv
tb/tb_cmyk_rgb_pixel_converter_core.sv
